// ===== hw/rtl/pcr_pkg.sv =====
// Shared types and constants for the particle contact resolver.
// Depends on nothing; the front, queue, back and top files use it by scoped names.
`default_nettype none
package pcr_pkg;

    // Fixed point format of all vectors.
    localparam int FRAC_BITS = 16;
    localparam int REST_BITS = 16;
    localparam int REST_W    = REST_BITS + 1;

    // Widths of the front pipeline values.
    localparam int PROD_W = 51;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NSW    = SUM_W - FRAC_BITS;
    localparam int DW     = NSW + 2;
    localparam int NM_W   = 18;
    localparam int MAGW   = NM_W + DW;

    // Widths of the back end arithmetic.
    localparam int NUM_W = 32;
    localparam int DEN_W = 33;
    localparam int ACCW  = MAGW + NUM_W;
    localparam int AIW   = $clog2(ACCW);
    localparam int QW    = 31;
    localparam int CMPW  = 64;
    localparam int LANES = 6;

    // One contact as it enters the block.
    typedef struct packed {
        logic signed [2:0][31:0] vel_a;
        logic signed [2:0][31:0] vel_b;
        logic signed [2:0][17:0] normal;
        logic signed [31:0]      depth;
        logic [31:0]             mass_a;
        logic [31:0]             mass_b;
    } t_contact;

    // One classified contact waiting for the back end.
    typedef struct packed {
        logic [2:0][MAGW-1:0] magv;
        logic [2:0][MAGW-1:0] magm;
        logic [2:0]           nneg;
        logic [31:0]          mass_a;
        logic [31:0]          mass_b;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ===== hw/rtl/pcr_front.sv =====
// Front pipeline: separating speed, impulse and the per-axis magnitudes.
// Depends on pcr_pkg.
`default_nettype none
module pcr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire pcr_pkg::t_contact             i_contact,
    input  wire logic [pcr_pkg::REST_W-1:0]    i_restitution,
    input  wire logic                          i_q_full,
    output logic                               o_stall,
    output logic                               o_push,
    output pcr_pkg::t_job                      o_job
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1 registers.
    logic signed [2:0][pcr_pkg::PROD_W-1:0] r_prod;
    logic [2:0][pcr_pkg::NM_W-1:0]          r_nm1, r_nm2, r_nm3;
    logic [2:0]                             r_nneg1, r_nneg2, r_nneg3;
    logic [30:0]                            r_dm1, r_dm2, r_dm3;
    logic [31:0]                            r_ma1, r_ma2, r_ma3, r_mb1, r_mb2, r_mb3;
    // Stage 2 and 3 registers.
    logic [pcr_pkg::NSW-1:0]                r_negsep;
    logic                                   r_do_vel;
    logic [pcr_pkg::DW-1:0]                 r_delta;
    // Stage 4 is the job.
    pcr_pkg::t_job                          r_job;

    logic signed [2:0][32:0]                diff;
    logic signed [2:0][pcr_pkg::PROD_W-1:0] dext, next_n;
    logic signed [pcr_pkg::SUM_W-1:0]       sum;
    logic [pcr_pkg::SUM_W-1:0]              negsum;
    logic [pcr_pkg::NSW+pcr_pkg::REST_W-1:0] rprod;
    logic two;

    // The whole pipeline moves unless the last stage cannot enter the queue.
    assign o_stall = r_v4 && i_q_full;
    assign en      = !o_stall;
    assign o_push  = r_v4 && en;
    assign o_job   = r_job;
    assign two     = i_contact.mass_b != 32'd0;

    // Relative velocity times normal, per axis.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {i_contact.vel_a[i][31], i_contact.vel_a[i]}
                    - (two ? {i_contact.vel_b[i][31], i_contact.vel_b[i]} : 33'sd0);
            dext[i]   = {{(pcr_pkg::PROD_W-33){diff[i][32]}}, diff[i]};
            next_n[i] = {{(pcr_pkg::PROD_W-18){i_contact.normal[i][17]}},
                         i_contact.normal[i]};
        end
    end

    // Sum of the three products and its negated magnitude.
    assign sum = {{2{r_prod[0][pcr_pkg::PROD_W-1]}}, r_prod[0]}
               + {{2{r_prod[1][pcr_pkg::PROD_W-1]}}, r_prod[1]}
               + {{2{r_prod[2][pcr_pkg::PROD_W-1]}}, r_prod[2]};
    assign negsum = -sum;

    assign rprod = r_negsep * i_restitution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload stages carry no reset.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i]  <= dext[i] * next_n[i];
                r_nneg1[i] <= i_contact.normal[i][17];
                r_nm1[i]   <= i_contact.normal[i][17] ? 18'(-i_contact.normal[i])
                                                      : 18'(i_contact.normal[i]);
            end
            r_dm1 <= (i_contact.depth > 32'sd0) ? i_contact.depth[30:0] : 31'd0;
            r_ma1 <= i_contact.mass_a;
            r_mb1 <= i_contact.mass_b;

            // Stage 2: the impulse applies when the speed is not positive.
            r_do_vel <= sum < $signed({{(pcr_pkg::SUM_W-1){1'b0}}, 1'b1} << pcr_pkg::FRAC_BITS);
            r_negsep <= sum[pcr_pkg::SUM_W-1]
                      ? negsum[pcr_pkg::SUM_W-1:pcr_pkg::FRAC_BITS] : '0;
            r_nm2 <= r_nm1;  r_nneg2 <= r_nneg1;  r_dm2 <= r_dm1;
            r_ma2 <= r_ma1;  r_mb2 <= r_mb1;

            // Stage 3: delta is restitution share plus the closing speed.
            r_delta <= r_do_vel
                     ? (pcr_pkg::DW'(rprod >> pcr_pkg::REST_BITS) + pcr_pkg::DW'(r_negsep))
                     : '0;
            r_nm3 <= r_nm2;  r_nneg3 <= r_nneg2;  r_dm3 <= r_dm2;
            r_ma3 <= r_ma2;  r_mb3 <= r_mb2;

            // Stage 4: magnitudes along each axis.
            for (int i = 0; i < 3; i++) begin
                r_job.magv[i] <= r_nm3[i] * r_delta;
                r_job.magm[i] <= pcr_pkg::MAGW'(r_nm3[i] * r_dm3);
            end
            r_job.nneg   <= r_nneg3;
            r_job.mass_a <= r_ma3;
            r_job.mass_b <= r_mb3;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcr_queue.sv =====
// Two-entry queue of classified contacts between front and back.
// Depends on pcr_pkg.
`default_nettype none
module pcr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pcr_pkg::t_job i_job,
    input  wire logic          i_pop,
    output pcr_pkg::t_job      o_head,
    output pcr_pkg::t_qstat    o_stat
);

    pcr_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
    assign o_head       = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcr_back.sv =====
// Back end: shares the change by mass with six serial multiply-divide lanes.
// Depends on pcr_pkg; holds the result output register.
`default_nettype none
module pcr_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcr_pkg::t_job     i_head,
    input  wire pcr_pkg::t_qstat   i_qstat,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic                   o_which,
    output logic                   o_last,
    output logic [5:0][31:0]       o_vals
);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CHK, ST_DIV, ST_OUT} t_state;

    t_state                        r_st;
    logic                          r_p;
    logic [4:0]                    r_cnt;
    logic [pcr_pkg::ACCW-1:0]      r_acc [pcr_pkg::LANES];
    logic [pcr_pkg::DEN_W-1:0]     r_rem [pcr_pkg::LANES];
    logic [pcr_pkg::QW-1:0]        r_q   [pcr_pkg::LANES];
    logic                          r_sat [pcr_pkg::LANES];
    logic                          r_valid, r_which, r_last;
    logic [5:0][31:0]              r_vals;

    logic                          two, out_free, last, emit;
    logic [pcr_pkg::NUM_W-1:0]     num;
    logic [pcr_pkg::DEN_W-1:0]     den;
    logic [pcr_pkg::MAGW-1:0]      mag  [pcr_pkg::LANES];
    logic                          neg  [pcr_pkg::LANES];
    logic [pcr_pkg::CMPW-1:0]      top  [pcr_pkg::LANES];
    logic [pcr_pkg::DEN_W:0]       rem2 [pcr_pkg::LANES];
    logic [31:0]                   res  [pcr_pkg::LANES];
    logic [pcr_pkg::AIW-1:0]       bidx;

    assign two      = i_head.mass_b != 32'd0;
    assign last     = !two || r_p;
    assign out_free = !r_valid || !i_stall;
    assign emit     = (r_st == ST_OUT) && out_free;
    assign o_pop    = emit && last;
    assign bidx     = pcr_pkg::AIW'(pcr_pkg::FRAC_BITS) + pcr_pkg::AIW'(r_cnt);

    // Share of this particle: its partner's mass over the total; a lone particle gets all.
    always_comb begin
        if (!two) begin
            num = 32'd1;
            den = 33'd1;
        end else begin
            num = r_p ? i_head.mass_a : i_head.mass_b;
            den = {1'b0, i_head.mass_a} + {1'b0, i_head.mass_b};
        end
    end

    // Lane operands, overflow test, quotient step and the signed result.
    always_comb begin
        for (int l = 0; l < pcr_pkg::LANES; l++) begin
            mag[l]  = (l < 3) ? i_head.magv[l % 3] : i_head.magm[l % 3];
            neg[l]  = i_head.nneg[l % 3] ^ r_p;
            top[l]  = pcr_pkg::CMPW'(r_acc[l] >> (pcr_pkg::FRAC_BITS + pcr_pkg::QW));
            rem2[l] = {r_rem[l], r_acc[l][bidx]};
            if (r_sat[l])
                res[l] = neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                res[l] = neg[l] ? -{1'b0, r_q[l]} : {1'b0, r_q[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_valid <= 1'b0;
            r_p     <= 1'b0;
            r_cnt   <= '0;
        end else begin
            // The output register fills on a result and empties when taken.
            if (emit) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_p   <= 1'b0;
                        r_cnt <= 5'd31;
                        r_st  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) r_st <= ST_CHK;
                end
                ST_CHK: begin
                    r_cnt <= 5'(pcr_pkg::QW - 1);
                    r_st  <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_which <= r_p;
                        r_last  <= last;
                        for (int l = 0; l < pcr_pkg::LANES; l++) r_vals[l] <= res[l];
                        if (last) begin
                            r_st <= ST_IDLE;
                        end else begin
                            r_p   <= 1'b1;
                            r_cnt <= 5'd31;
                            r_st  <= ST_MUL;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Datapath lanes: shift-add multiply, a range check, then one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < pcr_pkg::LANES; l++) begin
            if ((r_st == ST_IDLE) || ((r_st == ST_OUT) && out_free)) begin
                r_acc[l] <= '0;
            end else if (r_st == ST_MUL) begin
                r_acc[l] <= (r_acc[l] << 1)
                          + (num[r_cnt] ? pcr_pkg::ACCW'(mag[l]) : '0);
            end
            if (r_st == ST_CHK) begin
                r_sat[l] <= top[l] >= pcr_pkg::CMPW'(den);
                r_rem[l] <= top[l][pcr_pkg::DEN_W-1:0];
                r_q[l]   <= '0;
            end else if (r_st == ST_DIV) begin
                if (rem2[l] >= {1'b0, den}) begin
                    r_rem[l] <= pcr_pkg::DEN_W'(rem2[l] - {1'b0, den});
                    r_q[l]   <= {r_q[l][pcr_pkg::QW-2:0], 1'b1};
                end else begin
                    r_rem[l] <= pcr_pkg::DEN_W'(rem2[l]);
                    r_q[l]   <= {r_q[l][pcr_pkg::QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_which = r_which;
    assign o_last  = r_last;
    assign o_vals  = r_vals;

endmodule
`default_nettype wire

// ===== hw/rtl/particle_contact_resolver.sv =====
// Structure: 4 front stages feed the queue, and the back end serves one contact at a time.
// Per result the back end runs 32 multiply steps, a range check, 31 quotient steps
// and an output step, with a load step per contact; a two-particle contact repeats
// all but the load step for its second particle.
// The front keeps taking contacts while a two-entry queue has room.
// Reset (synchronous, active low) empties pipeline and queue, restitution is 32768.
`default_nettype none
module particle_contact_resolver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [16:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_vel_a_x,
    input  wire logic signed [31:0] i_vel_a_y,
    input  wire logic signed [31:0] i_vel_a_z,
    input  wire logic signed [31:0] i_vel_b_x,
    input  wire logic signed [31:0] i_vel_b_y,
    input  wire logic signed [31:0] i_vel_b_z,
    input  wire logic signed [17:0] i_normal_x,
    input  wire logic signed [17:0] i_normal_y,
    input  wire logic signed [17:0] i_normal_z,
    input  wire logic signed [31:0] i_depth,
    input  wire logic [31:0]        i_mass_a,
    input  wire logic [31:0]        i_mass_b,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_which_particle,
    output logic signed [31:0]      o_dvel_x,
    output logic signed [31:0]      o_dvel_y,
    output logic signed [31:0]      o_dvel_z,
    output logic signed [31:0]      o_move_x,
    output logic signed [31:0]      o_move_y,
    output logic signed [31:0]      o_move_z,
    output logic                    o_last_of_run
);

    logic [pcr_pkg::REST_W-1:0] r_restitution;
    pcr_pkg::t_contact          contact;
    pcr_pkg::t_job              job, head;
    pcr_pkg::t_qstat            qstat;
    logic                       push, pop;
    logic [5:0][31:0]           vals;

    // Restitution register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_restitution <= 17'd32768;
        else if (i_cfg_we) r_restitution <= i_cfg_data;
    end

    // Gather the input transaction.
    always_comb begin
        contact.vel_a  = {i_vel_a_z, i_vel_a_y, i_vel_a_x};
        contact.vel_b  = {i_vel_b_z, i_vel_b_y, i_vel_b_x};
        contact.normal = {i_normal_z, i_normal_y, i_normal_x};
        contact.depth  = i_depth;
        contact.mass_a = i_mass_a;
        contact.mass_b = i_mass_b;
    end

    pcr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .i_contact(contact),
        .i_restitution(r_restitution), .i_q_full(qstat.full), .o_stall(o_in_stall),
        .o_push(push), .o_job(job)
    );

    pcr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job),
        .i_pop(pop), .o_head(head), .o_stat(qstat)
    );

    pcr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_qstat(qstat),
        .o_pop(pop), .i_stall(i_out_stall), .o_valid(o_out_valid),
        .o_which(o_which_particle), .o_last(o_last_of_run), .o_vals(vals)
    );

    assign o_dvel_x = vals[0];
    assign o_dvel_y = vals[1];
    assign o_dvel_z = vals[2];
    assign o_move_x = vals[3];
    assign o_move_y = vals[4];
    assign o_move_z = vals[5];

endmodule
`default_nettype wire

// ===== hw/rtl/pcr_checker.sv =====
// Port-level checks for the particle contact resolver, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module pcr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_which_particle,
    input wire logic o_last_of_run
);

    // A stalled result transaction stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // The second particle always closes its contact.
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_which_particle |-> o_last_of_run)
        else $error("second particle not last");

    // After a first result that is not last is taken, any result shown directly after it is the second.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> !o_out_valid || o_which_particle)
        else $error("pair broken");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind particle_contact_resolver pcr_checker u_pcr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_which_particle(o_which_particle),
    .o_last_of_run(o_last_of_run)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for particle_contact_resolver: random and directed contacts.
// Depends on pcr_pkg and the particle_contact_resolver RTL; expected results come
// from a behavioral impulse and correction calculator held here.
`timescale 1ns / 1ps
module testbench;

    // Clock, reset and configuration.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [16:0] i_cfg_data = '0;

    // Input channel.
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_vel_a_x = '0, i_vel_a_y = '0, i_vel_a_z = '0;
    logic signed [31:0] i_vel_b_x = '0, i_vel_b_y = '0, i_vel_b_z = '0;
    logic signed [17:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [31:0] i_depth = '0;
    logic [31:0] i_mass_a = 32'd1, i_mass_b = '0;

    // Output channel.
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_which_particle, o_last_of_run;
    logic signed [31:0] o_dvel_x, o_dvel_y, o_dvel_z;
    logic signed [31:0] o_move_x, o_move_y, o_move_z;

    typedef struct {
        logic signed [31:0] va [3];
        logic signed [31:0] vb [3];
        logic signed [17:0] n [3];
        logic signed [31:0] depth;
        logic [31:0] ma;
        logic [31:0] mb;
    } contact_t;

    typedef struct {
        logic which;
        logic signed [31:0] dvel [3];
        logic signed [31:0] move [3];
        logic last;
    } share_t;

    contact_t pending_contacts[$];
    share_t expected_shares[$];
    logic [16:0] restitution_model = 17'd32768;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit failed = 1'b0;
    bit hold_send = 1'b0;

    particle_contact_resolver dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Truncated, saturated trunc(mag * num / (den << 16)) with a sign.
    function automatic logic signed [31:0] scaled_share(logic [127:0] mag, bit neg,
                                                        logic [127:0] num,
                                                        logic [127:0] den);
        logic [127:0] q;
        q = (mag * num) / (den << 16);
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return 32'(-$signed({1'b0, q[31:0]}));
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // Shift toward zero.
    function automatic longint shift_toward_zero(longint x, int s);
        if (x < 0) return -((-x) >>> s);
        return x >>> s;
    endfunction

    // Compute the per-particle shares of one contact and queue them.
    task automatic predict_contact(contact_t c);
        longint sum, sep, delta, nsep, depth;
        bit two;
        int count;
        logic [127:0] num, den, nm, dm, pm;
        share_t r;
        sum = 0;
        delta = 0;
        two = c.mb != 0;
        count = two ? 2 : 1;
        depth = c.depth;
        for (int i = 0; i < 3; i++)
            sum += (longint'(c.va[i]) - (two ? longint'(c.vb[i]) : 0)) * longint'(c.n[i]);
        sep = shift_toward_zero(sum, 16);
        if (sep <= 0) begin
            nsep = shift_toward_zero(-sep * longint'({1'b0, restitution_model}), 16);
            delta = nsep - sep;
        end
        dm = delta < 0 ? -delta : delta;
        pm = depth < 0 ? -depth : depth;
        for (int p = 0; p < count; p++) begin
            num = !two ? 1 : (p == 0 ? c.mb : c.ma);
            den = !two ? 1 : 128'(c.ma) + 128'(c.mb);
            r.which = p[0];
            r.last = (p == count - 1);
            for (int i = 0; i < 3; i++) begin
                nm = c.n[i] < 0 ? -longint'(c.n[i]) : longint'(c.n[i]);
                r.dvel[i] = (sep <= 0) ? scaled_share(nm * dm,
                    ((c.n[i] < 0) != (delta < 0)) != (p == 1), num, den) : 0;
                r.move[i] = (depth > 0) ? scaled_share(nm * pm,
                    (c.n[i] < 0) != (p == 1), num, den) : 0;
            end
            expected_shares.push_back(r);
        end
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 65536 * 8)) - 32'sd262144;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [17:0] rand_normal();
        if ($urandom_range(0, 9) == 0) return 18'($urandom);
        return 18'($signed($urandom_range(0, 131072)) - 32'sd65536);
    endfunction

    function automatic contact_t random_contact();
        contact_t c;
        for (int i = 0; i < 3; i++) begin
            c.va[i] = rand_word();
            c.vb[i] = rand_word();
            c.n[i] = rand_normal();
        end
        c.depth = rand_word();
        case ($urandom_range(0, 4))
            0: c.ma = 32'hFFFF_FFFF;
            1: c.ma = $urandom_range(1, 1 << 20);
            default: c.ma = $urandom | 32'd1;
        endcase
        case ($urandom_range(0, 4))
            0: c.mb = 0;
            1: c.mb = 32'hFFFF_FFFF;
            2: c.mb = $urandom_range(1, 1 << 20);
            default: c.mb = $urandom;
        endcase
        return c;
    endfunction

    // Driver: presents queued contacts and the random output stall on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_stall)) begin
            if (pending_contacts.size() > 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                contact_t c;
                c = pending_contacts.pop_front();
                i_vel_a_x <= c.va[0]; i_vel_a_y <= c.va[1]; i_vel_a_z <= c.va[2];
                i_vel_b_x <= c.vb[0]; i_vel_b_y <= c.vb[1]; i_vel_b_z <= c.vb[2];
                i_normal_x <= c.n[0]; i_normal_y <= c.n[1]; i_normal_z <= c.n[2];
                i_depth <= c.depth;
                i_mass_a <= c.ma;
                i_mass_b <= c.mb;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Predict on each accepted input transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            contact_t c;
            c.va[0] = i_vel_a_x; c.va[1] = i_vel_a_y; c.va[2] = i_vel_a_z;
            c.vb[0] = i_vel_b_x; c.vb[1] = i_vel_b_y; c.vb[2] = i_vel_b_z;
            c.n[0] = i_normal_x; c.n[1] = i_normal_y; c.n[2] = i_normal_z;
            c.depth = i_depth;
            c.ma = i_mass_a;
            c.mb = i_mass_b;
            predict_contact(c);
        end
    end

    // Monitor: check each accepted output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_shares.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1'b1;
            end else begin
                share_t e;
                logic signed [31:0] got_dvel [3];
                logic signed [31:0] got_move [3];
                e = expected_shares.pop_front();
                got_dvel = '{o_dvel_x, o_dvel_y, o_dvel_z};
                got_move = '{o_move_x, o_move_y, o_move_z};
                if (o_which_particle !== e.which) begin
                    $error("which_particle exp %0d got %0d", e.which, o_which_particle);
                    failed = 1'b1;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, o_last_of_run);
                    failed = 1'b1;
                end
                for (int i = 0; i < 3; i++) begin
                    if (got_dvel[i] !== e.dvel[i]) begin
                        $error("dvel[%0d] exp %0d got %0d", i, e.dvel[i], got_dvel[i]);
                        failed = 1'b1;
                    end
                    if (got_move[i] !== e.move[i]) begin
                        $error("move[%0d] exp %0d got %0d", i, e.move[i], got_move[i]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Wait until every queued contact has been taken and answered.
    task automatic drain();
        while (pending_contacts.size() > 0 || i_in_valid || expected_shares.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_restitution(logic [16:0] value);
        @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        restitution_model = value;
    endtask

    task automatic add_directed(logic signed [31:0] v, logic signed [17:0] n,
                                logic signed [31:0] d, logic [31:0] ma, logic [31:0] mb);
        contact_t c;
        c = random_contact();
        c.va = '{v, -v, v};
        c.vb = '{-v, v, 32'sd0};
        c.n = '{n, -n, 18'sd0};
        c.depth = d;
        c.ma = ma;
        c.mb = mb;
        pending_contacts.push_back(c);
    endtask

    // Stimulus and phase control.
    initial begin
        int phase_pct [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{11, 11}};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed contacts: extremes, separating, single particle, no depth.
        add_directed(32'sh7FFF_FFFF, 18'sd65536, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_directed(32'sh8000_0000, -18'sd65536, 32'sh8000_0000, 32'd1, 32'd1);
        add_directed(32'sh8000_0000, 18'sd65536, 32'sd65536, 32'd65536, 32'd0);
        add_directed(32'sh7FFF_FFFF, 18'sd65536, 32'sd0, 32'd1, 32'd0);
        add_directed(32'sd65536, -18'sd65536, -32'sd1, 32'd65536, 32'd131072);
        add_directed(32'sd0, 18'sd0, 32'sd1, 32'hFFFF_FFFF, 32'd1);
        add_directed(-32'sd1, 18'sh1FFFF, 32'sd1, 32'd3, 32'd7);
        add_directed(32'sd12345, 18'sh20000, 32'sd99, 32'd1, 32'hFFFF_FFFF);
        drain();

        // Random phases across restitution settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_restitution(17'd0);
                1: write_restitution(17'd65536);
                2: write_restitution(17'h1FFFF);
                default: write_restitution(17'($urandom_range(0, 65536)));
            endcase
            send_idle_pct = phase_pct[ph % 4][0];
            stall_pct = phase_pct[ph % 4][1];
            for (int k = 0; k < 56; k++) pending_contacts.push_back(random_contact());
            if (ph == 5) begin
                // Hold the sender until the block has answered everything.
                wait (pending_contacts.size() < 30);
                hold_send = 1'b1;
                while (i_in_valid || expected_shares.size() > 0) @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain();
        end

        if (!failed) begin
            $display("particle_contact_resolver verification clean");
        end else begin
            $display("particle_contact_resolver verification failed");
        end
        $finish;
    end

    // Watchdog: bounds a run of about 460 contacts through the back end, stalls included.
    initial begin
        #20ms;
        $display("particle_contact_resolver verification failed");
        $finish;
    end

endmodule
